FILE: sv/scp_pkg.sv
package scp_pkg;

	typedef struct packed {
		logic        func;
		logic [3:0]  byte_address;
		logic        access_word;
		logic [15:0] write_data;
		logic        keyboard_present;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [3:0]  contrast_level;
		logic [1:0]  scope_mode;
		logic [4:0]  image_unit_ctrl;
		logic        keyboard_hold;
		logic        hrl_select;
		logic        sram_write_enable;
		logic        power_off;
	} rsp_t;

	typedef struct packed {
		logic [1:0] machine_model;
		logic [7:0] version_major;
		logic [7:0] version_minor;
	} cfg_t;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_MODEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MAJOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MINOR = 2'd2;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic [2:0] REG_CONTRAST = 3'd0;
	localparam logic [2:0] REG_SCOPE    = 3'd1;
	localparam logic [2:0] REG_KEYBOARD = 3'd3;
	localparam logic [2:0] REG_IMAGE    = 3'd4;
	localparam logic [2:0] REG_MODEL    = 3'd5;
	localparam logic [2:0] REG_SRAM     = 3'd6;
	localparam logic [2:0] REG_POWER    = 3'd7;

	localparam logic [1:0] MODEL_EARLY   = 2'd0;
	localparam logic [1:0] MODEL_COMPACT = 2'd1;
	localparam logic [1:0] MODEL_030     = 2'd2;

	localparam logic [7:0] CODE_EARLY   = 8'hFF;
	localparam logic [7:0] CODE_COMPACT = 8'hFE;
	localparam logic [7:0] CODE_030     = 8'hDC;

	localparam logic [1:0] VER_IDLE  = 2'd0;
	localparam logic [1:0] VER_ID    = 2'd1;
	localparam logic [1:0] VER_MAJOR = 2'd2;
	localparam logic [1:0] VER_MINOR = 2'd3;

	localparam logic [1:0] PWR_IDLE    = 2'd0;
	localparam logic [1:0] PWR_GOT_00  = 2'd1;
	localparam logic [1:0] PWR_GOT_0F  = 2'd2;
	localparam logic [1:0] PWR_LATCHED = 2'd3;

	localparam logic [7:0] BYTE_OPEN     = 8'hFF;
	localparam logic [7:0] HI_NIBBLE_SET = 8'hF0;
	localparam logic [7:0] SCOPE_FILL    = 8'hF8;
	localparam logic [7:0] SRAM_UNLOCK   = 8'h31;
	localparam logic [7:0] VER_ARM       = 8'h58;
	localparam logic [7:0] VER_ID_CHAR   = 8'h36;
	localparam logic [3:0] PWR_FIRST     = 4'h0;
	localparam logic [3:0] PWR_NEXT      = 4'hF;

endpackage

FILE: sv/scp_core.sv
module scp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  scp_pkg::req_t req,
	input  scp_pkg::cfg_t cfg,
	output scp_pkg::rsp_t rsp
);
	import scp_pkg::*;

	logic [3:0] contrast_q;
	logic [1:0] scope_q;
	logic [4:0] image_q;
	logic [1:0] pwr_count_q;
	logic [1:0] ver_count_q;
	logic       hrl_q;
	logic       kb_hold_q;
	logic       sram_q;

	logic [3:0] contrast_d;
	logic [1:0] scope_d;
	logic [4:0] image_d;
	logic [1:0] pwr_count_d;
	logic [1:0] ver_count_d;
	logic       hrl_d;
	logic       kb_hold_d;
	logic       sram_d;
	logic       pulse;

	logic       odd;
	logic [2:0] reg_sel;
	logic [7:0] wdat;
	logic [7:0] rbyte;
	logic [7:0] model_code;

	assign odd     = req.byte_address[0] | req.access_word;
	assign reg_sel = req.byte_address[3:1];
	assign wdat    = req.write_data[7:0];

	always_comb begin
		case (cfg.machine_model)
			MODEL_COMPACT: model_code = CODE_COMPACT;
			MODEL_030:     model_code = CODE_030;
			default:       model_code = CODE_EARLY;
		endcase
	end

	always_comb begin
		contrast_d  = contrast_q;
		scope_d     = scope_q;
		image_d     = image_q;
		pwr_count_d = pwr_count_q;
		ver_count_d = ver_count_q;
		hrl_d       = hrl_q;
		kb_hold_d   = kb_hold_q;
		sram_d      = sram_q;
		pulse       = 1'b0;
		rbyte       = BYTE_OPEN;

		if (req.func == FUNC_WRITE) begin
			if (odd) begin
				case (reg_sel)
					REG_CONTRAST: contrast_d = wdat[3:0];
					REG_SCOPE:    scope_d = wdat[1:0];
					REG_KEYBOARD: begin
						kb_hold_d = ~wdat[3];
						hrl_d     = wdat[1];
					end
					REG_IMAGE:    image_d = wdat[4:0];
					REG_SRAM: begin
						sram_d      = (wdat == SRAM_UNLOCK);
						ver_count_d = (wdat == VER_ARM) ? VER_ID : VER_IDLE;
					end
					REG_POWER: begin
						case (pwr_count_q)
							PWR_IDLE: begin
								pwr_count_d = (wdat[3:0] == PWR_FIRST) ? PWR_GOT_00 : PWR_IDLE;
							end
							PWR_GOT_00: begin
								pwr_count_d = (wdat[3:0] == PWR_NEXT) ? PWR_GOT_0F : PWR_IDLE;
							end
							PWR_GOT_0F: begin
								pulse       = (wdat[3:0] == PWR_NEXT);
								pwr_count_d = pulse ? PWR_LATCHED : PWR_IDLE;
							end
							default: pwr_count_d = PWR_LATCHED;
						endcase
					end
					default: ;
				endcase
			end
		end else if (odd) begin
			case (reg_sel)
				REG_CONTRAST: rbyte = HI_NIBBLE_SET | {4'h0, contrast_q};
				REG_SCOPE:    rbyte = SCOPE_FILL | {6'h00, scope_q};
				REG_KEYBOARD: begin
					rbyte = HI_NIBBLE_SET | {4'h0, req.keyboard_present, 1'b0, hrl_q, 1'b0};
				end
				REG_MODEL:    rbyte = model_code;
				REG_SRAM: begin
					// step the version readback while armed
					case (ver_count_q)
						VER_ID: begin
							rbyte       = VER_ID_CHAR;
							ver_count_d = VER_MAJOR;
						end
						VER_MAJOR: begin
							rbyte       = cfg.version_major;
							ver_count_d = VER_MINOR;
						end
						VER_MINOR: begin
							rbyte       = cfg.version_minor;
							ver_count_d = VER_IDLE;
						end
						default: rbyte = BYTE_OPEN;
					endcase
				end
				default: rbyte = BYTE_OPEN;
			endcase
		end
	end

	always_comb begin
		rsp.read_data = '0;
		if (req.func == FUNC_READ) begin
			rsp.read_data = {(req.access_word ? BYTE_OPEN : 8'h00), rbyte};
		end
		rsp.contrast_level    = contrast_d;
		rsp.scope_mode        = scope_d;
		rsp.image_unit_ctrl   = image_d;
		rsp.keyboard_hold     = kb_hold_d;
		rsp.hrl_select        = hrl_d;
		rsp.sram_write_enable = sram_d;
		rsp.power_off         = pulse;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q  <= '0;
			scope_q     <= '0;
			image_q     <= '0;
			pwr_count_q <= PWR_IDLE;
			ver_count_q <= VER_IDLE;
			hrl_q       <= 1'b0;
			kb_hold_q   <= 1'b0;
			sram_q      <= 1'b0;
		end else if (advance) begin
			contrast_q  <= contrast_d;
			scope_q     <= scope_d;
			image_q     <= image_d;
			pwr_count_q <= pwr_count_d;
			ver_count_q <= ver_count_d;
			hrl_q       <= hrl_d;
			kb_hold_q   <= kb_hold_d;
			sram_q      <= sram_d;
		end
	end

endmodule

FILE: sv/system_control_port.sv
// System control port: seven byte registers on the odd bytes of a 16-byte window,
// one request per clock while rsp is not stalled. A request accepted on req lands in
// an input register, is decoded against the port state, and its response is
// registered in the response register, which raises rsp_valid; the port state changes
// when the request moves into the response register. rsp stalls hold the pipe, and
// req_ready drops only when both the input and response registers are full. Configuration
// writes are taken every cycle (cfg_ready is always high) and must be made while the
// port is idle.
module system_control_port (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  scp_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output scp_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [scp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data
);
	import scp_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	logic  rsp_valid_q;
	rsp_t  rsp_q;
	rsp_t  rsp_next;
	cfg_t  cfg_q;
	logic  advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MACHINE_MODEL: cfg_q.machine_model <= cfg_data[1:0];
				CFG_VERSION_MAJOR: cfg_q.version_major <= cfg_data;
				CFG_VERSION_MINOR: cfg_q.version_minor <= cfg_data;
				default: ;
			endcase
		end
	end

	scp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.cfg     (cfg_q),
		.rsp     (rsp_next)
	);

endmodule

FILE: sv/scp_checker.sv
module scp_assertions (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input scp_pkg::rsp_t rsp
);
	import scp_pkg::*;

	// response register is empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// the power-off pulse only comes from a write, and writes return zero
	a_pulse_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.power_off |-> rsp.read_data == 16'h0000)
		else $error("power-off pulse on a read");

	// upper byte is zero for byte reads and writes, all ones for word reads
	a_upper_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.read_data[15:8] == 8'h00 || rsp.read_data[15:8] == 8'hFF)
		else $error("bad upper read byte");

endmodule

bind system_control_port scp_assertions u_scp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
